// File: rtl/core/brl_pkg.sv
// Package for the button remap, learn and report block.
// Holds the beat structs, map type, shared constants and the pin select helper.
// Depends on nothing.
`default_nettype none

package brl_pkg;

  localparam int unsigned PIN_COUNT = 10;
  localparam int unsigned NIB_W     = 4;
  localparam int unsigned MAP_DEPTH = 16;
  localparam int unsigned MAP_W     = 40;
  localparam int unsigned IDX_W     = 4;

  localparam logic [7:0] AXIS_MIN = 8'd0;
  localparam logic [7:0] AXIS_MID = 8'd128;
  localparam logic [7:0] AXIS_MAX = 8'd255;

  localparam logic [MAP_W-1:0] STORED_MAP_RST = 40'h98_7654_3210;

  typedef logic [MAP_DEPTH-1:0][NIB_W-1:0] brl_map_t;

  typedef struct packed {
    logic [PIN_COUNT-1:0] button_pins;
    logic                 dir_left;
    logic                 dir_right;
    logic                 dir_up;
    logic                 dir_down;
  } brl_in_t;

  typedef struct packed {
    logic                 report_valid;
    logic [7:0]           axis_x;
    logic [7:0]           axis_y;
    logic [PIN_COUNT-1:0] buttons;
    logic                 led_on;
    logic                 save_map;
    logic [MAP_W-1:0]     new_map;
  } brl_out_t;

  typedef struct packed {
    logic report;
    logic save;
    logic led;
  } brl_step_t;

  function automatic logic pin_at(input logic [PIN_COUNT-1:0] pins,
                                  input logic [IDX_W-1:0]     idx,
                                  input logic [IDX_W-1:0]     bc);
    logic [MAP_DEPTH-1:0] wide;
    wide = MAP_DEPTH'(pins);
    return (idx < bc) && wide[idx];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/brl_learn.sv
// Mode sequencer: startup, blink, scan, pause and normal phases, map storage.
// Produces the next active map and the per-beat step status.
// Depends on brl_pkg.
`default_nettype none

module brl_learn #(
  parameter int unsigned BUTTON_COUNT = 10,
  parameter int unsigned HOLD_TICKS   = 20,
  parameter int unsigned PAUSE_TICKS  = 20,
  parameter int unsigned BLINK_TICKS  = 40
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic [brl_pkg::MAP_W-1:0]           stored_map_i,
  input  logic [brl_pkg::PIN_COUNT-1:0]       pins_i,
  input  logic                                any_pressed_i,
  output brl_pkg::brl_map_t                   map_d_o,
  output brl_pkg::brl_step_t                  step_o
);
  import brl_pkg::*;

  typedef enum logic [2:0] {
    PH_STARTUP,
    PH_BLINK,
    PH_SCAN,
    PH_PAUSE,
    PH_NORMAL
  } phase_e;

  localparam logic [IDX_W-1:0] BcLim    = IDX_W'(BUTTON_COUNT);
  localparam logic [4:0]       HoldLim  = 5'(HOLD_TICKS);
  localparam logic [5:0]       PauseLim = 6'(PAUSE_TICKS);
  localparam logic [5:0]       BlinkLim = 6'(BLINK_TICKS);

  phase_e           phase_q, phase_d;
  brl_map_t         active_q, active_d;
  brl_map_t         learned_q, learned_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [IDX_W-1:0] cand_q, cand_d;
  logic [4:0]       hold_q, hold_d;
  logic [5:0]       wait_q, wait_d;
  logic             led_q, led_d;

  logic             report;
  logic             save;
  logic             assigned;
  logic             cand_pressed;
  logic [IDX_W-1:0] cand_inc;
  logic [5:0]       wait_inc;
  logic [4:0]       hold_inc;
  logic [63:0]      stored_wide;

  assign stored_wide  = 64'(stored_map_i);
  assign wait_inc     = wait_q + 6'd1;
  assign hold_inc     = hold_q + 5'd1;
  assign cand_inc     = cand_q + IDX_W'(1);
  assign cand_pressed = pin_at(pins_i, cand_q, BcLim);

  always_comb begin
    assigned = 1'b0;
    for (int j = 0; j < MAP_DEPTH; j++) begin
      if ((IDX_W'(j) < slot_q) && (learned_q[j] == cand_q)) begin
        assigned = 1'b1;
      end
    end
  end

  always_comb begin
    phase_d   = phase_q;
    active_d  = active_q;
    learned_d = learned_q;
    slot_d    = slot_q;
    cand_d    = cand_q;
    hold_d    = hold_q;
    wait_d    = wait_q;
    led_d     = led_q;
    report    = 1'b0;
    save      = 1'b0;
    case (phase_q)
      PH_STARTUP: begin
        if (pins_i[8] && pins_i[9]) begin
          phase_d = PH_BLINK;
          wait_d  = '0;
          slot_d  = '0;
          cand_d  = '0;
          hold_d  = '0;
        end else begin
          for (int i = 0; i < MAP_DEPTH; i++) begin
            if (i < BUTTON_COUNT) begin
              active_d[i] = stored_wide[NIB_W*i +: NIB_W];
            end
          end
          phase_d = PH_NORMAL;
          report  = 1'b1;
        end
      end
      PH_BLINK: begin
        wait_d = wait_inc;
        if (wait_inc[0]) begin
          led_d = ~led_q;
        end
        if (wait_inc >= BlinkLim) begin
          phase_d = PH_SCAN;
          wait_d  = '0;
          hold_d  = '0;
          cand_d  = '0;
        end
      end
      PH_SCAN: begin
        hold_d = hold_inc;
        if (cand_pressed && !assigned) begin
          led_d = 1'b1;
          if (hold_inc >= HoldLim) begin
            led_d             = 1'b0;
            learned_d[slot_q] = cand_q;
            slot_d            = slot_q + IDX_W'(1);
            hold_d            = '0;
            wait_d            = '0;
            phase_d           = PH_PAUSE;
          end
        end else begin
          led_d  = ~led_q;
          hold_d = '0;
          cand_d = (cand_inc >= BcLim) ? '0 : cand_inc;
        end
      end
      PH_PAUSE: begin
        wait_d = wait_inc;
        if (wait_inc >= PauseLim) begin
          wait_d = '0;
          cand_d = '0;
          hold_d = '0;
          if (slot_q >= BcLim) begin
            for (int i = 0; i < MAP_DEPTH; i++) begin
              if (i < BUTTON_COUNT) begin
                active_d[i] = learned_q[i];
              end
            end
            save    = 1'b1;
            phase_d = PH_NORMAL;
          end else begin
            phase_d = PH_SCAN;
          end
        end
      end
      default: begin
        phase_d = PH_NORMAL;
        report  = 1'b1;
      end
    endcase
    if (report) begin
      led_d = any_pressed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_STARTUP;
      for (int i = 0; i < MAP_DEPTH; i++) begin
        active_q[i] <= NIB_W'(i);
      end
      learned_q <= '0;
      slot_q    <= '0;
      cand_q    <= '0;
      hold_q    <= '0;
      wait_q    <= '0;
      led_q     <= 1'b1;
    end else if (step_i) begin
      phase_q   <= phase_d;
      active_q  <= active_d;
      learned_q <= learned_d;
      slot_q    <= slot_d;
      cand_q    <= cand_d;
      hold_q    <= hold_d;
      wait_q    <= wait_d;
      led_q     <= led_d;
    end
  end

  assign map_d_o     = active_d;
  assign step_o.report = report;
  assign step_o.save   = save;
  assign step_o.led    = led_d;

endmodule

`default_nettype wire

// File: rtl/core/brl_report.sv
// Report former: axes, remapped buttons and packed map for one result beat.
// Depends on brl_pkg.
`default_nettype none

module brl_report #(
  parameter int unsigned BUTTON_COUNT = 10
) (
  input  brl_pkg::brl_in_t   in_i,
  input  brl_pkg::brl_map_t  map_i,
  input  brl_pkg::brl_step_t step_i,
  output logic               any_pressed_o,
  output brl_pkg::brl_out_t  res_o
);
  import brl_pkg::*;

  localparam logic [IDX_W-1:0] BcLim = IDX_W'(BUTTON_COUNT);

  logic [PIN_COUNT-1:0] btn;
  logic [MAP_W-1:0]     packed_map;
  logic [7:0]           ax_x;
  logic [7:0]           ax_y;

  always_comb begin
    btn        = '0;
    packed_map = '0;
    for (int i = 0; i < PIN_COUNT; i++) begin
      if (i < BUTTON_COUNT) begin
        btn[i]                       = pin_at(in_i.button_pins, map_i[i], BcLim);
        packed_map[NIB_W*i +: NIB_W] = map_i[i];
      end
    end
  end

  assign ax_x = in_i.dir_left ? AXIS_MIN : (in_i.dir_right ? AXIS_MAX : AXIS_MID);
  assign ax_y = in_i.dir_down ? AXIS_MIN : (in_i.dir_up ? AXIS_MAX : AXIS_MID);

  assign any_pressed_o = |btn;

  assign res_o.report_valid = step_i.report;
  assign res_o.axis_x       = step_i.report ? ax_x : AXIS_MID;
  assign res_o.axis_y       = step_i.report ? ax_y : AXIS_MID;
  assign res_o.buttons      = step_i.report ? btn : '0;
  assign res_o.led_on       = step_i.led;
  assign res_o.save_map     = step_i.save;
  assign res_o.new_map      = packed_map;

endmodule

`default_nettype wire

// File: rtl/core/button_remap_learn_and_report_top.sv
// Top level of the button remap, learn and report block.
// Input beat register, sequencer, report former, result register, config register.
// Depends on brl_pkg, brl_learn and brl_report.

// One input beat is one sample tick and yields exactly one result beat. The block
// takes a beat every clock cycle while the result side does not stall; an accepted
// beat waits in the input register, and the single pass of tick logic writes its result
// to the result register. Backpressure on the result side holds the result register and
// then the input register. The stored map written through the config channel is
// sampled only on the first tick after reset; write it before that tick. There is
// no clearing pass after reset.
`default_nettype none

module button_remap_learn_and_report_top #(
  parameter int unsigned BUTTON_COUNT = 10,
  parameter int unsigned HOLD_TICKS   = 20,
  parameter int unsigned PAUSE_TICKS  = 20,
  parameter int unsigned BLINK_TICKS  = 40
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  brl_pkg::brl_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output brl_pkg::brl_out_t           out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [brl_pkg::MAP_W-1:0]   cfg_data_i
);
  import brl_pkg::*;

  brl_in_t          in_q;
  logic             in_vld_q;
  brl_out_t         out_q;
  logic             out_vld_q;
  logic [MAP_W-1:0] stored_q;

  logic      fire;
  brl_map_t  map_d;
  brl_step_t step;
  brl_out_t  res;
  logic      any_pressed;

  assign fire        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || fire;
  assign cfg_ready_o = 1'b1;

  brl_learn #(
    .BUTTON_COUNT (BUTTON_COUNT),
    .HOLD_TICKS   (HOLD_TICKS),
    .PAUSE_TICKS  (PAUSE_TICKS),
    .BLINK_TICKS  (BLINK_TICKS)
  ) u_learn (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (fire),
    .stored_map_i  (stored_q),
    .pins_i        (in_q.button_pins),
    .any_pressed_i (any_pressed),
    .map_d_o       (map_d),
    .step_o        (step)
  );

  brl_report #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_report (
    .in_i          (in_q),
    .map_i         (map_d),
    .step_i        (step),
    .any_pressed_o (any_pressed),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= STORED_MAP_RST;
    end else if (cfg_valid_i) begin
      stored_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_save_no_report : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.save_map |-> !out_data_o.report_valid)
    else $error("save beat carries a report");

  a_report_led : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.report_valid |-> out_data_o.led_on == (out_data_o.buttons != '0))
    else $error("report led does not follow buttons");

  a_idle_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.report_valid |->
      out_data_o.axis_x == AXIS_MID && out_data_o.axis_y == AXIS_MID &&
      out_data_o.buttons == '0)
    else $error("non-report beat has report fields set");

  a_fire_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("processed tick lost its result");

endmodule

`default_nettype wire
